### design/stint_pkg.sv
`timescale 1ns / 1ps

package stint_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int FRAC_BITS   = 5;

   localparam int ADDR_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
   localparam int ENT_W  = 7;
   localparam int LIM_W  = (CNT_W > ENT_W) ? CNT_W : ENT_W;

   // Divider: dividend is the 16-bit offset scaled up, divisor the 17-bit span.
   localparam int NUM_W  = 16 + FRAC_BITS;
   localparam int DEN_W  = 17;
   localparam int STEP_W = $clog2(NUM_W);
   localparam int Q_W    = NUM_W + 1;
   localparam int PROD_W = Q_W + 9;
   localparam int IB_W   = ADDR_W + 10;
   localparam int BS_W   = IB_W + FRAC_BITS;
   localparam int T_W    = ((PROD_W > BS_W) ? PROD_W : BS_W) + 1;
   localparam int EXT_W  = (T_W > 33) ? T_W : 33;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 10;

   localparam logic [CSR_IDX_W-1:0] CSR_TEMP_MINIMUM      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TEMP_MAXIMUM      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DEGREES_PER_ENTRY = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ENTRIES_IN_USE    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FALLING_CURVE     = 3'd4;

   localparam logic OP_LOAD    = 1'b0;
   localparam logic OP_CONVERT = 1'b1;

   typedef struct packed {
      logic signed [7:0] temp_minimum;
      logic signed [9:0] temp_maximum;
      logic [7:0]        degrees_per_entry;
      logic [ENT_W-1:0]  entries_in_use;
      logic              falling_curve;
   } cfg_type;

   typedef struct packed {
      logic load;
      logic walk_first;
      logic walk_next;
      logic miss;
      logic capture;
      logic div_step;
      logic mul;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic hit;
      logic last;
      logic count_zero;
   } sts_type;

endpackage

### design/stint_ram.sv
`timescale 1ns / 1ps

module stint_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### design/stint_csr.sv
`timescale 1ns / 1ps

module stint_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [stint_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [stint_pkg::CSR_DATA_W-1:0]  csr_data,
   output stint_pkg::cfg_type                cfg
);

   import stint_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    wr;

   assign csr_ready = 1'b1;
   assign wr        = csr_valid & csr_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         case (csr_index)
            CSR_TEMP_MINIMUM:      cfg_in.temp_minimum      = $signed(csr_data[7:0]);
            CSR_TEMP_MAXIMUM:      cfg_in.temp_maximum      = $signed(csr_data[9:0]);
            CSR_DEGREES_PER_ENTRY: cfg_in.degrees_per_entry = csr_data[7:0];
            CSR_ENTRIES_IN_USE:    cfg_in.entries_in_use    = csr_data[ENT_W-1:0];
            CSR_FALLING_CURVE:     cfg_in.falling_curve     = csr_data[0];
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.temp_minimum      <= 8'sd0;
         cfg_ff.temp_maximum      <= 10'sd100;
         cfg_ff.degrees_per_entry <= 8'd5;
         cfg_ff.entries_in_use    <= 7'd1;
         cfg_ff.falling_curve     <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### design/stint_ctrl.sv
`timescale 1ns / 1ps

module stint_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                req_opcode,
   output logic                busy,
   input  stint_pkg::sts_type  sts,
   output stint_pkg::cmd_type  cmd
);

   import stint_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_WALK = 5'b00010,
      ST_DIV  = 5'b00100,
      ST_MUL  = 5'b01000,
      ST_FIN  = 5'b10000
   } state_type;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_opcode == OP_LOAD) begin
                  cmd.load = 1'b1;
               end else begin
                  cmd.walk_first = 1'b1;
                  if (sts.count_zero) begin
                     cmd.miss = 1'b1;
                     state_in = ST_FIN;
                  end else begin
                     state_in = ST_WALK;
                  end
               end
            end
         end
         ST_WALK: begin
            if (sts.hit) begin
               cmd.capture = 1'b1;
               step_in     = '0;
               state_in    = ST_DIV;
            end else if (sts.last) begin
               cmd.miss = 1'b1;
               state_in = ST_FIN;
            end else begin
               cmd.walk_next = 1'b1;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (step_ff == STEP_W'(NUM_W - 1)) begin
               state_in = ST_MUL;
            end else begin
               step_in = step_ff + STEP_W'(1);
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_FIN;
         end
         ST_FIN: begin
            cmd.finish = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

### design/stint_dp.sv
`timescale 1ns / 1ps

module stint_dp (
   input  logic                clock,
   input  logic                reset,
   input  stint_pkg::cfg_type  cfg,
   input  stint_pkg::cmd_type  cmd,
   output stint_pkg::sts_type  sts,
   input  logic [5:0]          req_entry_index,
   input  logic [15:0]         req_entry_value,
   input  logic [15:0]         req_reading,
   output logic                rsp_valid,
   output logic signed [31:0]  rsp_temperature,
   output logic                rsp_divide_by_zero
);

   import stint_pkg::*;

   logic [15:0]              reading_ff, reading_in;
   logic [ADDR_W-1:0]        idx_ff, idx_in;
   logic [15:0]              prev_ff, prev_in;
   logic                     nomatch_ff, nomatch_in;
   logic [NUM_W-1:0]         quo_ff, quo_in;
   logic [DEN_W-1:0]         rem_ff, rem_in;
   logic [DEN_W-1:0]         den_ff, den_in;
   logic                     yneg_ff, yneg_in;
   logic                     yzero_ff, yzero_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [BS_W-1:0]   base_ff, base_in;
   logic signed [31:0]       temp_ff, temp_in;
   logic                     dz_ff, dz_in;
   logic                     valid_ff, valid_in;

   logic                     ram_we;
   logic [ADDR_W-1:0]        ram_raddr;
   logic [15:0]              c;
   logic [LIM_W-1:0]         lim;
   logic [15:0]              prev_eff;
   logic [15:0]              x;
   logic [DEN_W-1:0]         y_rise;
   logic [DEN_W-1:0]         y;
   logic [DEN_W-1:0]         y_abs;
   logic [DEN_W:0]           shifted;
   logic [DEN_W:0]           diff;
   logic signed [Q_W-1:0]    q_mag;
   logic signed [Q_W-1:0]    q_s;
   logic signed [8:0]        dg_s;
   logic [ADDR_W+7:0]        dmul;
   logic signed [IB_W-1:0]   ib;
   logic signed [EXT_W-1:0]  t_ext;
   logic signed [31:0]       t_sat;
   logic signed [31:0]       tmax_scaled;

   assign ram_we    = cmd.load && (int'(req_entry_index) < TABLE_DEPTH);
   assign ram_raddr = cmd.walk_first ? '0 : idx_ff + ADDR_W'(1);

   stint_ram #(
      .WIDTH (16),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ADDR_W'(req_entry_index)),
      .wr_data (req_entry_value),
      .rd_addr (ram_raddr),
      .rd_data (c)
   );

   assign lim = (LIM_W'(cfg.entries_in_use) > LIM_W'(TABLE_DEPTH)) ?
                LIM_W'(TABLE_DEPTH) : LIM_W'(cfg.entries_in_use);

   // The first entry has no predecessor in the table, so one is made up.
   assign prev_eff = (idx_ff == '0) ?
                     (cfg.falling_curve ? c - 16'd1 : c + 16'd1) : prev_ff;

   assign sts.hit        = cfg.falling_curve ? (c >= reading_ff) : (c <= reading_ff);
   assign sts.last       = (LIM_W'(idx_ff) + LIM_W'(1)) == lim;
   assign sts.count_zero = (lim == '0);

   assign x      = cfg.falling_curve ? c - reading_ff : reading_ff - c;
   assign y_rise = {1'b0, prev_eff} - {1'b0, c};
   assign y      = cfg.falling_curve ? -y_rise : y_rise;
   assign y_abs  = y[DEN_W-1] ? -y : y;

   // One restoring step of the radix-2 divider.
   assign shifted = {rem_ff, quo_ff[NUM_W-1]};
   assign diff    = shifted - {1'b0, den_ff};

   assign q_mag = $signed({1'b0, quo_ff});
   assign q_s   = yzero_ff ? '0 : (yneg_ff ? -q_mag : q_mag);
   assign dg_s  = $signed({1'b0, cfg.degrees_per_entry});
   assign dmul  = (ADDR_W + 8)'(cfg.degrees_per_entry) * (ADDR_W + 8)'(idx_ff);
   assign ib    = $signed(IB_W'(dmul)) + IB_W'(cfg.temp_minimum);

   assign t_ext = EXT_W'(base_ff) - EXT_W'(prod_ff);
   always_comb begin
      if (t_ext > EXT_W'(32'sh7FFF_FFFF)) begin
         t_sat = 32'sh7FFF_FFFF;
      end else if (t_ext < EXT_W'(32'sh8000_0000)) begin
         t_sat = 32'sh8000_0000;
      end else begin
         t_sat = t_ext[31:0];
      end
   end

   assign tmax_scaled = 32'(cfg.temp_maximum) <<< FRAC_BITS;

   always_comb begin
      reading_in = reading_ff;
      idx_in     = idx_ff;
      prev_in    = prev_ff;
      nomatch_in = nomatch_ff;
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      den_in     = den_ff;
      yneg_in    = yneg_ff;
      yzero_in   = yzero_ff;
      prod_in    = prod_ff;
      base_in    = base_ff;
      temp_in    = temp_ff;
      dz_in      = dz_ff;
      valid_in   = cmd.finish;

      if (cmd.walk_first) begin
         reading_in = req_reading;
         idx_in     = '0;
         nomatch_in = 1'b0;
      end
      if (cmd.walk_next) begin
         idx_in  = idx_ff + ADDR_W'(1);
         prev_in = c;
      end
      if (cmd.miss) begin
         nomatch_in = 1'b1;
      end
      if (cmd.capture) begin
         quo_in   = NUM_W'(x) << FRAC_BITS;
         rem_in   = '0;
         den_in   = y_abs;
         yneg_in  = y[DEN_W-1];
         yzero_in = (y == '0);
      end
      if (cmd.div_step) begin
         if (!diff[DEN_W]) begin
            rem_in = diff[DEN_W-1:0];
            quo_in = {quo_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[DEN_W-1:0];
            quo_in = {quo_ff[NUM_W-2:0], 1'b0};
         end
      end
      if (cmd.mul) begin
         prod_in = PROD_W'(dg_s) * PROD_W'(q_s);
         base_in = BS_W'(ib) <<< FRAC_BITS;
      end
      if (cmd.finish) begin
         temp_in = nomatch_ff ? tmax_scaled : t_sat;
         dz_in   = nomatch_ff ? 1'b0 : yzero_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      reading_ff <= reading_in;
      idx_ff     <= idx_in;
      prev_ff    <= prev_in;
      nomatch_ff <= nomatch_in;
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      den_ff     <= den_in;
      yneg_ff    <= yneg_in;
      yzero_ff   <= yzero_in;
      prod_ff    <= prod_in;
      base_ff    <= base_in;
      temp_ff    <= temp_in;
      dz_ff      <= dz_in;
   end

   assign rsp_valid          = valid_ff;
   assign rsp_temperature    = temp_ff;
   assign rsp_divide_by_zero = dz_ff;

endmodule

### design/sensor_table_interpolator_unit.sv
`timescale 1ns / 1ps
// Channel   Direction  Transfer when           Payload
// request   in         start & !busy           req_opcode, req_entry_index,
//                                              req_entry_value, req_reading
// response  out        rsp_valid (one cycle)   rsp_temperature, rsp_divide_by_zero
// register  in         csr_valid & csr_ready   csr_index, csr_data
//
// Loads leave busy low. A conversion holds busy through the walk and, when an entry
// matches, through the divide and multiply steps, then through the finish state;
// the walk reads one entry a cycle and the divider yields one quotient bit a cycle.
// The result strobe comes in the same cycle that busy falls.
// Reset is synchronous; it clears the controller, the strobe and the settings, not the
// table or the datapath's working registers. The receiver cannot stall; csr_ready is high.

module sensor_table_interpolator_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_opcode,
   input  logic [5:0]                        req_entry_index,
   input  logic [15:0]                       req_entry_value,
   input  logic [15:0]                       req_reading,
   output logic                              rsp_valid,
   output logic signed [31:0]                rsp_temperature,
   output logic                              rsp_divide_by_zero,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [stint_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [stint_pkg::CSR_DATA_W-1:0]  csr_data
);

   import stint_pkg::*;

   cfg_type cfg;
   cmd_type cmd;
   sts_type sts;

   stint_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   stint_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_opcode (req_opcode),
      .busy       (busy),
      .sts        (sts),
      .cmd        (cmd)
   );

   stint_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg),
      .cmd                (cmd),
      .sts                (sts),
      .req_entry_index    (req_entry_index),
      .req_entry_value    (req_entry_value),
      .req_reading        (req_reading),
      .rsp_valid          (rsp_valid),
      .rsp_temperature    (rsp_temperature),
      .rsp_divide_by_zero (rsp_divide_by_zero)
   );

endmodule

### tb/interpolator_checker.sv
`timescale 1ns / 1ps

module interpolator_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic                             busy,
   input  logic                             req_opcode,
   input  logic [5:0]                       req_entry_index,
   input  logic [15:0]                      req_entry_value,
   input  logic [15:0]                      req_reading,
   input  logic                             rsp_valid,
   input  logic signed [31:0]               rsp_temperature,
   input  logic                             rsp_divide_by_zero,
   input  logic                             csr_valid,
   input  logic                             csr_ready,
   input  logic [stint_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [stint_pkg::CSR_DATA_W-1:0] csr_data,
   output int                               fail_count,
   output int                               pending_results,
   output int                               checked_results
);

   import stint_pkg::*;

   localparam longint TEMP_CEIL  = 64'sd2147483647;
   localparam longint TEMP_FLOOR = -64'sd2147483648;

   typedef struct {
      logic signed [31:0] temperature;
      logic               divide_by_zero;
   } temp_result_type;

   logic [15:0]     curve_copy [TABLE_DEPTH];
   cfg_type         settings;
   temp_result_type awaited_temps [$];
   int              errors = 0;
   int              checked = 0;

   // Walks the curve as the block does and interpolates against the previous entry.
   function automatic temp_result_type interpolate_reading(input logic [15:0] reading);
      temp_result_type res;
      int              walk_len;
      int              i;
      logic [15:0]     prev;
      longint          rd, c, p, x, y, q, t, scale, dpe;
      bit              found;
      scale = longint'(1) << FRAC_BITS;
      dpe   = settings.degrees_per_entry;
      rd    = reading;
      walk_len = (settings.entries_in_use > TABLE_DEPTH) ? TABLE_DEPTH
                                                         : settings.entries_in_use;
      // The first entry has no real predecessor, so one is made up next to it.
      prev = settings.falling_curve ? curve_copy[0] - 16'd1 : curve_copy[0] + 16'd1;
      t = longint'($signed(settings.temp_maximum)) * scale;
      res.divide_by_zero = 1'b0;
      found = 1'b0;
      for (i = 0; i < walk_len && !found; i++) begin
         c = curve_copy[i];
         p = prev;
         if (settings.falling_curve ? (c >= rd) : (c <= rd)) begin
            x = settings.falling_curve ? c - rd : rd - c;
            y = settings.falling_curve ? c - p : p - c;
            q = 0;
            if (y == 0)
               res.divide_by_zero = 1'b1;
            else
               q = (x * scale) / y;
            t = (dpe * i + longint'($signed(settings.temp_minimum))) * scale - dpe * q;
            found = 1'b1;
         end
         prev = curve_copy[i];
      end
      if (t > TEMP_CEIL)
         t = TEMP_CEIL;
      if (t < TEMP_FLOOR)
         t = TEMP_FLOOR;
      res.temperature = t[31:0];
      return res;
   endfunction

   always @(posedge clock) begin
      temp_result_type want;
      if (reset) begin
         settings.temp_minimum      = 8'sd0;
         settings.temp_maximum      = 10'sd100;
         settings.degrees_per_entry = 8'd5;
         settings.entries_in_use    = 7'd1;
         settings.falling_curve     = 1'b0;
         awaited_temps.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_TEMP_MINIMUM:      settings.temp_minimum      = csr_data[7:0];
               CSR_TEMP_MAXIMUM:      settings.temp_maximum      = csr_data[9:0];
               CSR_DEGREES_PER_ENTRY: settings.degrees_per_entry = csr_data[7:0];
               CSR_ENTRIES_IN_USE:    settings.entries_in_use    = csr_data[ENT_W-1:0];
               CSR_FALLING_CURVE:     settings.falling_curve     = csr_data[0];
               default: ;
            endcase
         end
         if (start && !busy) begin
            if (req_opcode == OP_LOAD)
               curve_copy[req_entry_index] = req_entry_value;
            else
               awaited_temps.push_back(interpolate_reading(req_reading));
         end
         if (rsp_valid) begin
            if (awaited_temps.size() == 0) begin
               $error("result transfer with no conversion outstanding: temperature %0d",
                      rsp_temperature);
               errors++;
            end else begin
               want = awaited_temps.pop_front();
               checked++;
               if (rsp_temperature !== want.temperature) begin
                  $error("temperature: expected %0d, got %0d", want.temperature,
                         rsp_temperature);
                  errors++;
               end
               if (rsp_divide_by_zero !== want.divide_by_zero) begin
                  $error("divide_by_zero: expected %0d, got %0d", want.divide_by_zero,
                         rsp_divide_by_zero);
                  errors++;
               end
            end
         end
      end
      fail_count      <= errors;
      pending_results <= awaited_temps.size();
      checked_results <= checked;
   end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

module tb;
   import stint_pkg::*;

   localparam int ITEM_TARGET    = 1950;
   localparam int STALL_LIMIT    = 2000;
   localparam int DRAIN_CYCLES   = 100;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic                  req_opcode = OP_LOAD;
   logic [5:0]            req_entry_index = '0;
   logic [15:0]           req_entry_value = '0;
   logic [15:0]           req_reading = '0;
   logic                  rsp_valid;
   logic signed [31:0]    rsp_temperature;
   logic                  rsp_divide_by_zero;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_TEMP_MINIMUM;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   int fail_count;
   int pending_results;
   int checked_results;

   logic [15:0] curve_shadow [TABLE_DEPTH];
   int          cur_entries = 1;
   logic        cur_fall = 1'b0;
   bit          idle_on = 1'b1;
   int          load_count = 0;
   int          convert_count = 0;
   int          setting_count = 0;
   int          stall_cycles = 0;
   int          phase;

   sensor_table_interpolator_unit u_top (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_opcode         (req_opcode),
      .req_entry_index    (req_entry_index),
      .req_entry_value    (req_entry_value),
      .req_reading        (req_reading),
      .rsp_valid          (rsp_valid),
      .rsp_temperature    (rsp_temperature),
      .rsp_divide_by_zero (rsp_divide_by_zero),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   interpolator_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_opcode         (req_opcode),
      .req_entry_index    (req_entry_index),
      .req_entry_value    (req_entry_value),
      .req_reading        (req_reading),
      .rsp_valid          (rsp_valid),
      .rsp_temperature    (rsp_temperature),
      .rsp_divide_by_zero (rsp_divide_by_zero),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .fail_count         (fail_count),
      .pending_results    (pending_results),
      .checked_results    (checked_results)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Any transfer on any channel counts as progress.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("tb: done, errors");
            $finish;
         end
      end
   end

   function automatic int pick_gap();
      int r;
      if (!idle_on)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 85)
         return $urandom_range(1, 3);
      if (r < 97)
         return $urandom_range(4, 15);
      return $urandom_range(20, 60);
   endfunction

   // Start stays high when the next item follows at once.
   task automatic send_item(input logic op, input logic [5:0] idx,
                            input logic [15:0] value, input logic [15:0] reading);
      int gap;
      req_opcode      <= op;
      req_entry_index <= idx;
      req_entry_value <= value;
      req_reading     <= reading;
      start           <= 1'b1;
      do @(posedge clock); while (busy);
      if (op == OP_LOAD) begin
         curve_shadow[idx] = value;
         load_count++;
      end else begin
         convert_count++;
      end
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic load_entry(input logic [5:0] idx, input logic [15:0] value);
      send_item(OP_LOAD, idx, value, 16'($urandom));
   endtask

   task automatic convert(input logic [15:0] reading);
      send_item(OP_CONVERT, 6'($urandom), 16'($urandom), reading);
   endtask

   // Holds off until every conversion has been answered and the block is idle.
   task automatic wait_quiet();
      start <= 1'b0;
      do @(posedge clock); while (pending_results != 0 || busy);
      repeat (4) @(posedge clock);
   endtask

   // Writes all five registers back to back, then one write to an unused index.
   task automatic set_curve(input logic [9:0] tmin, input logic [9:0] tmax,
                            input logic [9:0] dpe, input logic [9:0] entries,
                            input logic fall);
      int k;
      for (k = 0; k < 6; k++) begin
         case (k)
            0: begin
               csr_index <= CSR_TEMP_MINIMUM;
               csr_data  <= tmin;
            end
            1: begin
               csr_index <= CSR_TEMP_MAXIMUM;
               csr_data  <= tmax;
            end
            2: begin
               csr_index <= CSR_DEGREES_PER_ENTRY;
               csr_data  <= dpe;
            end
            3: begin
               csr_index <= CSR_ENTRIES_IN_USE;
               csr_data  <= entries;
            end
            4: begin
               csr_index <= CSR_FALLING_CURVE;
               csr_data  <= {9'($urandom), fall};
            end
            default: begin
               csr_index <= CSR_FALLING_CURVE + CSR_IDX_W'($urandom_range(1, 3));
               csr_data  <= CSR_DATA_W'($urandom);
            end
         endcase
         csr_valid <= 1'b1;
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
      cur_entries = entries[6:0];
      cur_fall    = fall;
      setting_count++;
   endtask

   // A tidy curve moves away from the reading so that the walk goes deep;
   // otherwise the table is filled with noise.
   task automatic build_curve(input bit tidy);
      longint level;
      int     i;
      int     stride;
      level = cur_fall ? $urandom_range(0, 3000) : 65535 - $urandom_range(0, 3000);
      for (i = 0; i < TABLE_DEPTH; i++) begin
         if (tidy)
            load_entry(6'(i), level[15:0]);
         else
            load_entry(6'(i), 16'($urandom));
         stride = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 1800);
         level  = cur_fall ? level + stride : level - stride;
         if (level > 65535)
            level = 65535;
         if (level < 0)
            level = 0;
      end
   endtask

   function automatic logic [15:0] pick_reading();
      int walk_len, j, lo, hi, r;
      walk_len = (cur_entries > TABLE_DEPTH) ? TABLE_DEPTH : cur_entries;
      r = $urandom_range(0, 99);
      if (walk_len == 0 || r >= 85)
         return 16'($urandom);
      j = $urandom_range(0, walk_len - 1);
      if (r < 10)
         return curve_shadow[j];
      if (r < 15)
         return (r < 12) ? 16'h0000 : 16'hFFFF;
      lo = curve_shadow[j];
      hi = (j == 0) ? lo : curve_shadow[j - 1];
      if (lo > hi) begin
         r  = lo;
         lo = hi;
         hi = r;
      end
      return 16'($urandom_range(lo, hi));
   endfunction

   initial begin
      int r;
      logic [9:0] entries;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Settings after reset: one entry walked on a rising curve.
      load_entry(6'd0, 16'hFFFF);
      load_entry(6'd63, 16'h0000);
      convert(16'hFFFF);
      convert(16'h0000);
      convert(16'd12345);

      wait_quiet();
      set_curve(10'h380, 10'h200, 10'd255, 10'd0, 1'b1);
      convert(16'd777);

      // Falling curve at the coldest extremes, with two equal neighbours.
      wait_quiet();
      set_curve(10'h380, 10'h200, 10'd255, 10'd4, 1'b1);
      load_entry(6'd0, 16'd0);
      load_entry(6'd1, 16'd100);
      load_entry(6'd2, 16'd100);
      load_entry(6'd3, 16'hFFFF);
      convert(16'd0);
      convert(16'd50);
      convert(16'd100);
      convert(16'd101);
      convert(16'hFFFF);

      // Rising curve at the hottest extremes.
      wait_quiet();
      set_curve(10'h07F, 10'h1FF, 10'd1, 10'd4, 1'b0);
      load_entry(6'd0, 16'd40000);
      load_entry(6'd1, 16'd30000);
      load_entry(6'd2, 16'd30000);
      load_entry(6'd3, 16'd10);
      convert(16'hFFFF);
      convert(16'd35000);
      convert(16'd30000);
      convert(16'd29999);
      convert(16'd5);

      phase = 0;
      while (load_count + convert_count < ITEM_TARGET) begin
         wait_quiet();
         idle_on = (phase % 3 != 2);
         r = $urandom_range(0, 99);
         if (r < 80)
            entries = {3'($urandom), 7'($urandom_range(1, 64))};
         else if (r < 90)
            entries = {3'($urandom), 7'($urandom_range(65, 127))};
         else
            entries = {3'($urandom), 7'd0};
         case (phase)
            0: set_curve(10'h080, 10'h200, 10'd255, 10'd64, 1'b1);
            1: set_curve(10'h07F, 10'h1FF, 10'd1, 10'd127, 1'b0);
            2: set_curve(10'($urandom), 10'($urandom), 10'($urandom_range(1, 255)),
                         10'd0, 1'($urandom));
            3: set_curve(10'($urandom), 10'($urandom), 10'd0, entries, 1'($urandom));
            default: set_curve(10'($urandom), 10'($urandom),
                               {2'($urandom), 8'($urandom_range(1, 255))}, entries,
                               1'($urandom));
         endcase
         build_curve(phase < 2 || $urandom_range(0, 4) != 0);
         repeat ($urandom_range(40, 110)) begin
            if ($urandom_range(0, 9) == 0)
               load_entry(6'($urandom), 16'($urandom));
            else
               convert(pick_reading());
         end
         phase++;
      end

      wait_quiet();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("tb: %0d table loads and %0d conversions over %0d register settings",
               load_count, convert_count, setting_count);
      $display("tb: %0d temperatures compared, %0d mismatches", checked_results, fail_count);
      if (fail_count == 0 && pending_results == 0)
         $display("tb: done, clean");
      else
         $display("tb: done, errors");
      $finish;
   end

endmodule
